// ===== rtl/hsva_pkg.sv =====
`timescale 1ns / 1ps
package hsva_pkg;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 16;
  localparam int unsigned FracOneW = FracW + 1;
  localparam int unsigned HueW = 19;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned AmountW = 10;
  localparam int unsigned IdxW = 1;
  localparam logic [FracOneW-1:0] FracOne = 17'h10000;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE = 2'd0,
    MODE_SAT  = 2'd1,
    MODE_VAL  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  localparam logic [IdxW-1:0] RegMode   = 1'b0;
  localparam logic [IdxW-1:0] RegAmount = 1'b1;

  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2,
    BASE_NONE  = 2'd3
  } base_e;

  // one item moving down the divider chain
  typedef struct packed {
    logic                vld;
    logic [ChanW-1:0]    mx;
    logic [ChanW-1:0]    d;
    logic                neg;
    base_e               base;
    logic [ChanW-1:0]    hrem;   // remainder for hue quotient
    logic [ChanW:0]      srem;   // remainder for saturation quotient
    logic [ChanW-1:0]    hnum;   // hue numerator bits still to feed
    logic [FracW:0]      hq;     // reaches 1.0 when |num| equals d
    logic [FracW:0]      sq;
  } cell_t;
endpackage

// ===== rtl/hsv_saturation_value_adjust_top.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Fields (low bit first)
// s_axis   | in  | tdata: red_in, green_in, blue_in
// m_axis   | out | tdata: red_out, green_out, blue_out
// cfg      | in  | cfg_idx_i 0 adjust_mode, 1 adjust_amount; cfg_data_i
// One pixel per cycle while the output is not stalled; 16 divider cells, then
// 3 back stages; the front min/max logic is combinational.
// The divider cells and the back stages set the latency; no state joins pixels.
// Reset clears valid bits and both registers.
// A stalled output stalls the whole chain; s_axis_tready is low only while
// a result waits at the output.
module hsv_saturation_value_adjust_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hsva_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [hsva_pkg::AmountW-1:0] cfg_data_i
);
  import hsva_pkg::*;
  mode_e mode_q;
  logic signed [AmountW-1:0] amount_q;
  logic en, ovld;
  logic [23:0] rgb;
  logic [ChanW-1:0] r, g, b, mx, mn, d, num;
  cell_t c0;
  cell_t chain [DivSteps+1];

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE; amount_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        RegMode:   mode_q <= mode_e'(cfg_data_i[ModeW-1:0]);
        default:   amount_q <= cfg_data_i;
      endcase
    end
  end

  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  always_comb begin
    r = s_axis_tdata[7:0]; g = s_axis_tdata[15:8]; b = s_axis_tdata[23:16];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    c0 = '0;
    c0.vld = s_axis_tvalid;
    c0.mx = mx; c0.d = d;
    c0.srem = {1'b0, d};  // d <= mx: integer quotient bit is set only when d equals mx
    if (d == '0) begin
      c0.base = BASE_NONE; num = '0; c0.neg = 1'b0;
    end else if (r == mx) begin
      c0.base = BASE_RED; c0.neg = g < b; num = c0.neg ? b - g : g - b;
    end else if (g == mx) begin
      c0.base = BASE_GREEN; c0.neg = b < r; num = c0.neg ? r - b : b - r;
    end else begin
      c0.base = BASE_BLUE; c0.neg = r < g; num = c0.neg ? g - r : r - g;
    end
    // |num| <= d: integer quotient bit is set only when |num| equals d
    c0.hq = {{FracW{1'b0}}, (d != '0 && num == d)};
    c0.hrem = (d != '0 && num == d) ? '0 : num;
    c0.hnum = '0;
    c0.sq = {{FracW{1'b0}}, (mx != '0 && d == mx)};
    c0.srem = (mx != '0 && d == mx) ? '0 : {1'b0, d};
  end

  assign chain[0] = c0;
  for (genvar k = 0; k < DivSteps; k++) begin : g_cell
    hsva_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .c_i(chain[k]), .c_o(chain[k+1])
    );
  end

  hsva_back u_back (
    .clk_i, .rst_ni, .en_i(en), .c_i(chain[DivSteps]),
    .mode_i(mode_q), .amount_i(amount_q), .vld_o(ovld), .rgb_o(rgb)
  );

  assign m_axis_tvalid = ovld;
  assign m_axis_tdata = rgb;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  a_mode_rst: assert property (@(posedge clk_i)
    !rst_ni |=> mode_q == MODE_NONE || rst_ni) else $error("mode reset");
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("ready in stall");
endmodule

// ===== rtl/hsva_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division step for the hue and saturation quotients.
module hsva_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  hsva_pkg::cell_t c_i,
  output hsva_pkg::cell_t c_o
);
  import hsva_pkg::*;
  cell_t c_d, c_q;
  logic vld_q;
  logic [ChanW:0]   ht;
  logic [ChanW+1:0] st;

  always_comb begin
    c_d = c_i;
    ht = {c_i.hrem, c_i.hnum[ChanW-1]};
    c_d.hnum = {c_i.hnum[ChanW-2:0], 1'b0};
    if (c_i.d != '0 && ht >= {1'b0, c_i.d}) begin
      c_d.hrem = ChanW'(ht - {1'b0, c_i.d});
      c_d.hq = {c_i.hq[FracW-1:0], 1'b1};
    end else begin
      c_d.hrem = ht[ChanW-1:0];
      c_d.hq = {c_i.hq[FracW-1:0], 1'b0};
    end
    st = {c_i.srem, 1'b0};
    if (c_i.mx != '0 && st >= {2'b0, c_i.mx}) begin
      c_d.srem = (ChanW+1)'(st - {2'b0, c_i.mx});
      c_d.sq = {c_i.sq[FracW-1:0], 1'b1};
    end else begin
      c_d.srem = st[ChanW:0];
      c_d.sq = {c_i.sq[FracW-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= c_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  always_comb begin
    c_o = c_q;
    c_o.vld = vld_q;
  end
endmodule

// ===== rtl/hsva_back.sv =====
`timescale 1ns / 1ps
// HSV adjust and back conversion, three register stages.
module hsva_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  hsva_pkg::cell_t          c_i,
  input  hsva_pkg::mode_e          mode_i,
  input  logic signed [hsva_pkg::AmountW-1:0] amount_i,
  output logic                     vld_o,
  output logic [3*hsva_pkg::ChanW-1:0] rgb_o
);
  import hsva_pkg::*;
  logic [FracOneW-1:0] val, sat, sadj, vadj;
  logic signed [FracOneW+2:0] sum_s, sum_v, amt;
  logic [HueW-1:0] hue;
  logic [ChanW+FracW-1:0] vmul;
  logic [FracW:0] sq;

  // stage 1
  logic a_vld_q;
  logic [FracOneW-1:0] a_s_q, a_v_q;
  logic [2:0] a_i_q;
  logic [FracW-1:0] a_f_q;
  // stage 2
  logic b_vld_q;
  logic [FracOneW-1:0] b_v_q, b_sx_q, b_sy_q, b_sz_q;
  logic b_grey_q;
  logic [2:0] b_i_q;
  // stage 3
  logic c_vld_q;
  logic [FracOneW-1:0] c_r_q, c_g_q, c_b_q;
  logic [FracOneW-1:0] x, y, z, cr, cg, cb;
  logic [2*FracOneW-1:0] px, py, pz, psf, psg;
  logic [FracOneW+ChanW-1:0] tr, tg, tb;

  always_comb begin
    // V = ceil(mx*65536/255) = mx*257 + 1 if mx != 0, clipped
    vmul = (ChanW+FracW)'(c_i.mx) * (ChanW+FracW)'(257);
    val = (c_i.mx == '0) ? '0 : FracOneW'(vmul + 1'b1);
    if (c_i.mx == 8'hFF) val = FracOne;
    sq = c_i.sq;
    sat = (c_i.mx == '0) ? '0 : FracOneW'(sq);
    unique case (c_i.base)
      BASE_RED:   hue = c_i.neg ? HueW'(19'd393216 - {2'b0, c_i.hq}) : {2'b0, c_i.hq};
      BASE_GREEN: hue = c_i.neg ? HueW'(19'd131072 - {2'b0, c_i.hq})
                               : HueW'(19'd131072 + {2'b0, c_i.hq});
      BASE_BLUE:  hue = c_i.neg ? HueW'(19'd262144 - {2'b0, c_i.hq})
                               : HueW'(19'd262144 + {2'b0, c_i.hq});
      default:    hue = '0;
    endcase
    if (hue >= 19'd393216) hue = '0;
    amt = {{2{amount_i[AmountW-1]}}, amount_i, 8'b0};
    sum_s = $signed({3'b0, sat}) + amt;
    sum_v = $signed({3'b0, val}) + amt;
    sadj = sum_s < 0 ? '0 : (sum_s > $signed({3'b0, FracOne}) ? FracOne : FracOneW'(sum_s));
    vadj = sum_v < 0 ? '0 : (sum_v > $signed({3'b0, FracOne}) ? FracOne : FracOneW'(sum_v));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0; b_vld_q <= 1'b0; c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= c_i.vld; b_vld_q <= a_vld_q; c_vld_q <= b_vld_q;
    end
  end

  assign psf = {{FracOneW{1'b0}}, a_s_q} * {{(FracOneW+1){1'b0}}, a_f_q};
  assign psg = {{FracOneW{1'b0}}, a_s_q} * (2*FracOneW)'(FracOne - {1'b0, a_f_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_s_q <= (mode_i == MODE_SAT) ? sadj : sat;
      a_v_q <= (mode_i == MODE_VAL) ? vadj : val;
      a_i_q <= hue[HueW-1:FracW];
      a_f_q <= hue[FracW-1:0];
      b_v_q <= a_v_q;
      b_grey_q <= (a_s_q == '0);
      b_i_q <= a_i_q;
      b_sx_q <= FracOne - a_s_q;
      b_sy_q <= FracOne - FracOneW'(psf >> FracW);
      b_sz_q <= FracOne - FracOneW'(psg >> FracW);
      c_r_q <= cr; c_g_q <= cg; c_b_q <= cb;
    end
  end

  assign px = {{FracOneW{1'b0}}, b_v_q} * {{FracOneW{1'b0}}, b_sx_q};
  assign py = {{FracOneW{1'b0}}, b_v_q} * {{FracOneW{1'b0}}, b_sy_q};
  assign pz = {{FracOneW{1'b0}}, b_v_q} * {{FracOneW{1'b0}}, b_sz_q};
  assign x = FracOneW'(px >> FracW);
  assign y = FracOneW'(py >> FracW);
  assign z = FracOneW'(pz >> FracW);

  always_comb begin
    if (b_grey_q) begin
      cr = b_v_q; cg = b_v_q; cb = b_v_q;
    end else begin
      unique case (b_i_q)
        3'd0:    begin cr = b_v_q; cg = z; cb = x; end
        3'd1:    begin cr = y; cg = b_v_q; cb = x; end
        3'd2:    begin cr = x; cg = b_v_q; cb = z; end
        3'd3:    begin cr = x; cg = y; cb = b_v_q; end
        3'd4:    begin cr = z; cg = x; cb = b_v_q; end
        default: begin cr = b_v_q; cg = x; cb = y; end
      endcase
    end
  end

  // c*255 >> 16 = (c*256 - c) >> 16
  assign tr = {c_r_q, 8'b0} - (FracOneW+ChanW)'(c_r_q);
  assign tg = {c_g_q, 8'b0} - (FracOneW+ChanW)'(c_g_q);
  assign tb = {c_b_q, 8'b0} - (FracOneW+ChanW)'(c_b_q);
  assign rgb_o = {tb[FracW+ChanW-1:FracW], tg[FracW+ChanW-1:FracW], tr[FracW+ChanW-1:FracW]};
  assign vld_o = c_vld_q;

  logic unused;
  assign unused = ^{c_i.hrem, c_i.srem, c_i.hnum, c_i.d};
endmodule
